// ===== design/rouf_pkg.sv =====
// ----------------------------------------------------------------------------
// rouf_pkg
// Shared constants and command/status types for the root of unity finder.
// ----------------------------------------------------------------------------
package rouf_pkg;

  localparam int unsigned PRIME_BITS_DEF = 32;
  localparam int unsigned MAX_FACTORS    = 12;
  localparam int unsigned FIDX_W         = 4;
  localparam logic [15:0] MAX_TRIES_RST  = 16'd1024;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INPUT = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // latch n, p; setup working values
    OP_DIVN,      // start nc / q
    OP_DIVP,      // start d / q (factor exponent in p-1)
    OP_DIVS,      // start sc / q
    OP_NEXTQ,     // q <= q + 1
    OP_POW,       // start modular exponentiation
    OP_MODN,      // start p mod n
    OP_MUL        // start one modular product
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] sel;   // operand selector, meaning per op
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic rem_zero;
  } sts_t;

endpackage

// ===== design/rouf_divider.sv =====
// ----------------------------------------------------------------------------
// rouf_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rouf_divider #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  r_r, r_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [W:0]    trial;

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {r_r, q_r[W-1]};
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        r_nxt = W'(trial - {1'b0, d_r});
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    r_r   <= r_nxt;
    d_r   <= d_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign busy = busy_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

// ===== design/rouf_datapath.sv =====
// ----------------------------------------------------------------------------
// rouf_datapath
// Working registers, shared divider and modular multiply/exponentiate unit.
// ----------------------------------------------------------------------------
module rouf_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  rouf_pkg::cmd_t cmd,
  input  logic [31:0]    in_n,
  input  logic [31:0]    in_p,
  output rouf_pkg::sts_t sts,
  output logic [31:0]    div_q,
  output logic [31:0]    div_r,
  output logic [31:0]    pow_res
);
  import rouf_pkg::*;

  typedef enum logic [1:0] {
    P_IDLE, P_STEP, P_START, P_WAIT
  } pow_state_t;

  pow_state_t    pst_r;
  logic [31:0]   p_r, base_r, exp_r, acc_r;
  logic          acc_step_r;
  logic [63:0]   prod_r;
  logic [63:0]   rd_q, rd_r, rd_a, rd_b;
  logic          rd_busy, rd_start;
  logic          unused_ok;

  rouf_divider #(.W(64)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rd_start),
    .dividend (rd_a),
    .divisor  (rd_b),
    .busy     (rd_busy),
    .quot     (rd_q),
    .rem      (rd_r)
  );

  // divides from the controller, else product reduction mod p
  always_comb begin
    rd_start = 1'b0;
    rd_a     = 64'(in_n);
    rd_b     = 64'(in_p);
    if (cmd.op == OP_DIVN || cmd.op == OP_MODN) begin
      rd_start = 1'b1;
    end else if (pst_r == P_START) begin
      rd_start = 1'b1;
      rd_a     = prod_r;
      rd_b     = 64'(p_r);
    end
  end

  // square and multiply, exponent bits from the bottom
  always_ff @(posedge clk) begin
    if (cmd.op == OP_MODN) begin
      p_r <= in_n;
    end
    if (!rst_n) begin
      pst_r <= P_IDLE;
    end else begin
      case (pst_r)
        P_IDLE: begin
          if (cmd.op == OP_POW) begin
            base_r <= in_n;
            exp_r  <= in_p;
            acc_r  <= 32'd1;
            pst_r  <= P_STEP;
          end
        end
        P_STEP: begin
          if (exp_r == '0) begin
            pst_r <= P_IDLE;
          end else begin
            prod_r     <= exp_r[0] ? (64'(acc_r) * 64'(base_r)) :
                                     (64'(base_r) * 64'(base_r));
            acc_step_r <= exp_r[0];
            pst_r      <= P_START;
          end
        end
        P_START: begin
          pst_r <= P_WAIT;
        end
        P_WAIT: begin
          if (!rd_busy) begin
            if (acc_step_r) begin
              acc_r <= rd_r[31:0];
              exp_r <= {exp_r[31:1], 1'b0};
            end else begin
              base_r <= rd_r[31:0];
              exp_r  <= exp_r >> 1;
            end
            pst_r <= P_STEP;
          end
        end
        default: pst_r <= P_IDLE;
      endcase
    end
  end

  assign sts.busy     = rd_busy || (pst_r != P_IDLE);
  assign sts.rem_zero = (rd_r == '0);
  assign div_q        = rd_q[31:0];
  assign div_r        = rd_r[31:0];
  assign pow_res      = acc_r;

  assign unused_ok = ^{cmd.sel, rd_q[63:32], rd_r[63:32]};

endmodule

// ===== design/rouf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rouf_ctrl
// Search sequencer: validation, factorisation, candidate tests, inverse.
// ----------------------------------------------------------------------------
module rouf_ctrl #(
  parameter int unsigned PRIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [31:0]         in_order,
  input  logic [31:0]         in_modulus,
  input  logic [15:0]         max_tries,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         out_root,
  output logic [31:0]         out_inverse_root,
  output logic [1:0]          out_status,
  output rouf_pkg::cmd_t      cmd,
  output logic [31:0]         opa,
  output logic [31:0]         opb,
  input  rouf_pkg::sts_t      sts,
  input  logic [31:0]         div_q,
  input  logic [31:0]         div_r,
  input  logic [31:0]         pow_res
);
  import rouf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_MODN, S_MODN_W, S_FQ_CHK, S_FQ_DIV, S_FQ_W, S_FQ_LAST,
    S_FD_INIT, S_FD_DIV, S_FD_W, S_CAND, S_T_POW, S_T_POW_W, S_T_LOOP,
    S_T_QP, S_T_QP_W, S_T_RED, S_T_RED_W, S_ROOT, S_ROOT_W, S_INV, S_INV_W,
    S_DONE, S_OUT, S_SQ, S_SQ_W
  } state_t;

  state_t      state_r;
  logic [31:0] n_r, p_r, nc_r, q_r, d_r, sc_r, a_r, b_r, x_r, w_r;
  logic [31:0] fq_r [MAX_FACTORS];
  logic [31:0] fd_r [MAX_FACTORS];
  logic [5:0]  fk_r [MAX_FACTORS];
  logic [5:0]  fe_r [MAX_FACTORS];
  logic [FIDX_W-1:0] nf_r, i_r;
  logic [5:0]  k_r, l_r;
  logic        hit_r;
  logic [31:0] root_r, inv_r;
  logic [1:0]  st_r;
  logic        valid_r;
  logic [63:0] sqv;
  cmd_t        cmd_nxt;

  assign sqv = 64'(q_r) * 64'(q_r);

  // command issued in the states that start a datapath operation
  always_comb begin
    cmd_nxt = '{op: OP_NONE, sel: 3'd0};
    if (rst_n) begin
      case (state_r)
        S_MODN:             cmd_nxt.op = OP_MODN;
        S_FQ_DIV, S_FD_DIV: cmd_nxt.op = OP_DIVN;
        S_T_POW: begin
          if (i_r != nf_r) cmd_nxt.op = OP_POW;
        end
        S_T_LOOP: begin
          if (x_r != 32'd1 && l_r < fe_r[i_r]) cmd_nxt.op = OP_POW;
        end
        S_T_RED: begin
          if (l_r > fk_r[i_r]) cmd_nxt.op = OP_POW;
        end
        S_ROOT, S_INV:      cmd_nxt.op = OP_POW;
        default:            cmd_nxt.op = OP_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      nf_r    <= '0;
      i_r     <= '0;
    end else begin
      if (valid_r && !out_stall) valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && !valid_r) begin
          n_r <= in_order;
          p_r <= in_modulus;
          if (in_order == 32'd0 || in_modulus < 32'd3 ||
              (PRIME_BITS < 32 && (64'(in_modulus) >> PRIME_BITS) != 0)) begin
            root_r <= '0; inv_r <= '0; st_r <= ST_BAD_INPUT;
            state_r <= S_DONE;
          end else begin
            state_r <= S_MODN;
          end
        end
        S_MODN: begin
          opa <= p_r; opb <= n_r;
          state_r <= S_MODN_W;
        end
        S_MODN_W: if (!sts.busy && cmd.op == OP_NONE) begin
          if (div_r != 32'd1) begin
            root_r <= '0; inv_r <= '0; st_r <= ST_BAD_INPUT;
            state_r <= S_DONE;
          end else begin
            nc_r <= n_r; q_r <= 32'd2; nf_r <= '0; hit_r <= 1'b0; k_r <= '0;
            state_r <= S_FQ_CHK;
          end
        end
        S_FQ_CHK: begin
          if (sqv > 64'(nc_r)) begin
            state_r <= S_FQ_LAST;
          end else begin
            state_r <= S_FQ_DIV;
          end
        end
        S_FQ_DIV: begin
          opa <= nc_r; opb <= q_r;
          state_r <= S_FQ_W;
        end
        S_FQ_W: if (!sts.busy && cmd.op == OP_NONE) begin
          if (div_r == '0) begin
            nc_r <= div_q;
            k_r  <= k_r + 1'b1;
            state_r <= S_FQ_DIV;
          end else begin
            if (k_r != '0 && nf_r < FIDX_W'(MAX_FACTORS)) begin
              fq_r[nf_r] <= q_r; fk_r[nf_r] <= k_r; nf_r <= nf_r + 1'b1;
            end
            k_r <= '0;
            q_r <= q_r + 32'd1;
            state_r <= S_FQ_CHK;
          end
        end
        S_FQ_LAST: begin
          if (nc_r > 32'd1 && nf_r < FIDX_W'(MAX_FACTORS)) begin
            fq_r[nf_r] <= nc_r; fk_r[nf_r] <= 6'd1; nf_r <= nf_r + 1'b1;
          end
          sc_r <= p_r - 32'd1;
          i_r  <= '0;
          state_r <= S_FD_INIT;
        end
        S_FD_INIT: begin
          if (i_r == nf_r) begin
            a_r <= 32'd2;
            state_r <= S_CAND;
          end else begin
            d_r <= p_r - 32'd1; k_r <= '0; hit_r <= 1'b0;
            state_r <= S_FD_DIV;
          end
        end
        S_FD_DIV: begin
          opa <= hit_r ? sc_r : d_r; opb <= fq_r[i_r];
          state_r <= S_FD_W;
        end
        S_FD_W: if (!sts.busy && cmd.op == OP_NONE) begin
          if (!hit_r) begin
            if (div_r == '0) begin
              d_r <= div_q; k_r <= k_r + 1'b1;
            end else begin
              fd_r[i_r] <= d_r; fe_r[i_r] <= k_r; hit_r <= 1'b1;
            end
            state_r <= S_FD_DIV;
          end else if (div_r == '0) begin
            sc_r <= div_q;
            state_r <= S_FD_DIV;
          end else begin
            i_r <= i_r + 1'b1;
            state_r <= S_FD_INIT;
          end
        end
        S_CAND: begin
          if (a_r >= p_r || (a_r - 32'd1) > 32'(max_tries)) begin
            root_r <= '0; inv_r <= '0; st_r <= ST_EXHAUSTED;
            state_r <= S_DONE;
          end else begin
            b_r <= a_r; i_r <= '0;
            state_r <= S_T_POW;
          end
        end
        S_T_POW: begin
          if (i_r == nf_r) begin
            state_r <= S_ROOT;
          end else begin
            opa <= b_r; opb <= fd_r[i_r];
            l_r <= '0;
            state_r <= S_T_POW_W;
          end
        end
        S_T_POW_W: if (!sts.busy && cmd.op == OP_NONE) begin
          x_r <= pow_res;
          state_r <= S_T_LOOP;
        end
        S_T_LOOP: begin
          if (x_r == 32'd1) begin
            if (l_r < fk_r[i_r]) begin
              a_r <= a_r + 32'd1; state_r <= S_CAND;
            end else begin
              state_r <= S_T_RED;
            end
          end else if (l_r >= fe_r[i_r]) begin
            a_r <= a_r + 32'd1; state_r <= S_CAND;
          end else begin
            opa <= x_r; opb <= fq_r[i_r];
            l_r <= l_r + 1'b1;
            state_r <= S_T_QP_W;
          end
        end
        S_T_QP_W: if (!sts.busy && cmd.op == OP_NONE) begin
          x_r <= pow_res;
          state_r <= S_T_LOOP;
        end
        S_T_RED: begin
          if (l_r > fk_r[i_r]) begin
            opa <= b_r; opb <= fq_r[i_r];
            l_r <= l_r - 1'b1;
            state_r <= S_T_RED_W;
          end else begin
            i_r <= i_r + 1'b1;
            state_r <= S_T_POW;
          end
        end
        S_T_RED_W: if (!sts.busy && cmd.op == OP_NONE) begin
          b_r <= pow_res;
          state_r <= S_T_RED;
        end
        S_ROOT: begin
          opa <= b_r; opb <= sc_r;
          state_r <= S_ROOT_W;
        end
        S_ROOT_W: if (!sts.busy && cmd.op == OP_NONE) begin
          w_r <= pow_res;
          state_r <= S_INV;
        end
        S_INV: begin
          opa <= w_r; opb <= p_r - 32'd2;
          state_r <= S_INV_W;
        end
        S_INV_W: if (!sts.busy && cmd.op == OP_NONE) begin
          root_r <= w_r; inv_r <= pow_res; st_r <= ST_OK;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!valid_r) begin
            valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE) || valid_r;
  assign out_valid        = valid_r;
  assign out_root         = root_r;
  assign out_inverse_root = inv_r;
  assign out_status       = st_r;

  logic unused_c;
  assign unused_c = sts.rem_zero;

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_root)))
    else $error("result lost");
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_root == '0 && out_inverse_root == '0))
    else $error("error result not zero");
endmodule

// ===== design/root_of_unity_finder.sv =====
// ----------------------------------------------------------------------------
// root_of_unity_finder
// Primitive n-th root of unity modulo a prime, with its inverse.
// ----------------------------------------------------------------------------
// One transaction in, one result out. The block works on one item at a time:
// in_stall stays high from acceptance until the result has been taken, and a
// new transaction is taken from the cycle after that. Input failing the quick
// checks (order zero, modulus below 3 or wider than PRIME_BITS) goes straight
// to S_DONE, which raises out_valid. Everything else runs on a shared 64-bit
// bit-serial divider: it serves the p mod n check, each trial division step
// and the reduction of each modular product of a square-and-multiply
// exponentiation, which follows a registered multiply. An item whose modulus
// p gives p mod n other than 1 ends after the p mod n check; a search runs
// longer, set by the trial division bound sqrt(n), the number of candidate
// bases tried and the exponent sizes.
module root_of_unity_finder #(
  parameter int unsigned PRIME_BITS = rouf_pkg::PRIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_max_tries,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_order,
  input  logic [31:0] in_modulus,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_root,
  output logic [31:0] out_inverse_root,
  output logic [1:0]  out_status
);
  import rouf_pkg::*;

  logic [15:0]          max_tries_r;
  cmd_t                 cmd;
  sts_t                 sts;
  logic [31:0]          opa, opb;
  logic [31:0]          div_q, div_r, pow_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tries_r <= MAX_TRIES_RST;
    end else if (cfg_we) begin
      max_tries_r <= cfg_max_tries;
    end
  end

  rouf_ctrl #(.PRIME_BITS(PRIME_BITS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_order, .in_modulus,
    .max_tries(max_tries_r), .out_valid, .out_stall, .out_root,
    .out_inverse_root, .out_status, .cmd, .opa, .opb, .sts,
    .div_q, .div_r, .pow_res
  );

  rouf_datapath u_dp (
    .clk, .rst_n, .cmd, .in_n(opa), .in_p(opb), .sts,
    .div_q, .div_r, .pow_res
  );

endmodule

// ===== verif/root_of_unity_finder_tb.sv =====
// ----------------------------------------------------------------------------
// root_of_unity_finder_tb
// Self-checking bench for the primitive root of unity finder. Directed and
// random (order, modulus) transactions are driven under varying idle and stall
// rates; each result is compared with a behavioural root search run here.
// ----------------------------------------------------------------------------
module root_of_unity_finder_tb;
  import rouf_pkg::*;

  typedef struct {
    logic [31:0] order;
    logic [31:0] modulus;
  } req_t;

  typedef struct {
    logic [31:0] root;
    logic [31:0] inv;
    logic [1:0]  status;
  } root_res_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_max_tries;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_order;
  logic [31:0] in_modulus;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_root;
  logic [31:0] out_inverse_root;
  logic [1:0]  out_status;

  req_t      req_q[$];
  root_res_t root_expect_q[$];
  int        primes[$];
  logic [15:0] tries_reg;
  int        src_idle_pct;
  int        snk_stall_pct;
  int        errors = 0;
  longint    cycles = 0;

  root_of_unity_finder u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_max_tries    (cfg_max_tries),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_order         (in_order),
    .in_modulus       (in_modulus),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_root         (out_root),
    .out_inverse_root (out_inverse_root),
    .out_status       (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                              longint unsigned m);
    longint unsigned r;
    r = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) r = (r * b) % m;
      b = (b * b) % m;
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic root_res_t find_root(logic [31:0] order, logic [31:0] modulus,
                                          logic [15:0] tries);
    root_res_t       res;
    longint unsigned n, p, nc, q, sc, a, b, x, d;
    longint unsigned fq[12], fd[12];
    int              fk[12], fe[12];
    int              nf, i, l, k, e;
    bit              good;
    n = 64'(order);
    p = 64'(modulus);
    res.root = '0;
    res.inv = '0;
    res.status = ST_EXHAUSTED;
    nf = 0;
    if (n == 0 || p < 3 || p % n != 1) begin
      res.status = ST_BAD_INPUT;
      return res;
    end
    nc = n;
    for (q = 2; q * q <= nc; q++) begin
      if (nc % q == 0) begin
        k = 0;
        while (nc % q == 0) begin
          nc = nc / q;
          k++;
        end
        if (nf < 12) begin
          fq[nf] = q;
          fk[nf] = k;
          nf++;
        end
      end
    end
    if (nc > 1 && nf < 12) begin
      fq[nf] = nc;
      fk[nf] = 1;
      nf++;
    end
    sc = p - 1;
    for (i = 0; i < nf; i++) begin
      d = p - 1;
      e = 0;
      while (d % fq[i] == 0) begin
        d = d / fq[i];
        e++;
      end
      fd[i] = d;
      fe[i] = e;
      while (sc % fq[i] == 0) sc = sc / fq[i];
    end
    for (a = 2; a < p && a - 1 <= 64'(tries); a++) begin
      b = a;
      good = 1'b1;
      for (i = 0; i < nf && good; i++) begin
        x = pow_mod(b, fd[i], p);
        l = 0;
        while (x != 1 && good) begin
          if (l >= fe[i]) good = 1'b0;
          else begin
            x = pow_mod(x, fq[i], p);
            l++;
          end
        end
        if (good && l < fk[i]) good = 1'b0;
        if (good)
          for (; l > fk[i]; l--) b = pow_mod(b, fq[i], p);
      end
      if (good) begin
        res.root = 32'(pow_mod(b, sc, p));
        res.inv = 32'(pow_mod(64'(res.root), p - 2, p));
        res.status = ST_OK;
        break;
      end
    end
    return res;
  endfunction

  // driver: prediction taken at acceptance, next transaction loaded
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        root_expect_q.push_back(find_root(in_order, in_modulus, tries_reg));
      if (!in_valid || !in_stall) begin
        if (req_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid   <= 1'b1;
          in_order   <= req_q[0].order;
          in_modulus <= req_q[0].modulus;
          void'(req_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < snk_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    root_res_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (root_expect_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        exp_r = root_expect_q.pop_front();
        if (out_root !== exp_r.root) begin
          $error("root: expected %0d, got %0d", exp_r.root, out_root);
          errors++;
        end
        if (out_inverse_root !== exp_r.inv) begin
          $error("inverse_root: expected %0d, got %0d", exp_r.inv, out_inverse_root);
          errors++;
        end
        if (out_status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 40000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send(logic [31:0] order, logic [31:0] modulus);
    req_t r;
    r.order = order;
    r.modulus = modulus;
    req_q.push_back(r);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (req_q.size() != 0 || in_valid || root_expect_q.size() != 0);
  endtask

  task automatic write_tries(logic [15:0] v);
    @(posedge clk);
    cfg_we        <= 1'b1;
    cfg_max_tries <= v;
    tries_reg     = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random();
    int p, n, sel;
    int divs[$];
    logic [31:0] o, m;
    if ($urandom_range(99) < 85) begin
      sel = $urandom_range(19);
      if (sel == 0) begin
        p = 0;
        divs = '{2, 5, 10, 19, 38, 95, 190};
        send(divs[$urandom_range(divs.size() - 1)], 32'd4294967291);
      end else if (sel == 1) begin
        // small odd modulus, not necessarily prime, with n dividing m-1
        m = 2 * $urandom_range(4, 100) + 1;
        divs.delete();
        for (n = 2; n < m; n++) if ((m - 1) % n == 0) divs.push_back(n);
        send(divs[$urandom_range(divs.size() - 1)], m);
      end else begin
        p = primes[$urandom_range(primes.size() - 1)];
        for (n = 2; n < p; n++) if ((p - 1) % n == 0) divs.push_back(n);
        send(divs[$urandom_range(divs.size() - 1)], p);
      end
    end else begin
      do begin
        o = $urandom;
        m = $urandom;
      end while (o != 0 && m >= 3 && m % o == 1);
      send(o, m);
    end
  endtask

  initial begin
    int i, j, ph;
    bit isp;
    logic [15:0] tries_set[4];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_max_tries = '0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    tries_reg = MAX_TRIES_RST;
    for (i = 3; i < 5000; i++) begin
      isp = 1'b1;
      for (j = 2; j * j <= i; j++) if (i % j == 0) isp = 1'b0;
      if (isp) primes.push_back(i);
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset value of the register, special cases
    send(0, 7);
    send(1, 7);
    send(3, 2);
    send(2, 0);
    send(5, 7);
    send(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(2, 3);
    send(6, 7);
    send(3, 7);
    send(4, 5);
    send(12, 13);
    send(16, 17);
    send(96, 97);
    send(11, 23);
    send(65536, 65537);
    send(2, 32'd4294967291);
    send(190, 32'd4294967291);
    send(7, 15);
    send(4, 9);
    send(5, 21);
    drain();
    write_tries(16'd1);
    send(6, 7);
    send(2, 3);
    drain();
    write_tries(16'd0);
    send(2, 3);
    drain();
    write_tries(16'hFFFF);
    send(8, 9);
    send(8, 25);
    drain();

    tries_set = '{16'd1024, 16'hFFFF, 16'd2, 16'd300};
    for (ph = 0; ph < 4; ph++) begin
      write_tries(tries_set[ph]);
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 47; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 47; end
        default: begin src_idle_pct = 11; snk_stall_pct = 11; end
      endcase
      for (i = 0; i < 10; i++) send_random();
      drain();
      for (i = 0; i < 10; i++) send_random();
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && root_expect_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
